FILE: rtl/srpm_pkg.sv
// ----------------------------------------------------------------------------
// srpm_pkg
// Types and constants shared by the stereo RMS / peak meter.
// ----------------------------------------------------------------------------
`default_nettype none

package srpm_pkg;

    // Item function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    // Frame count saturates here (count register is 16 bits)
    localparam int unsigned MAX_FRAMES = 65535;
    localparam int unsigned FRAME_LIMIT = (MAX_FRAMES > 65535) ? 65535 : MAX_FRAMES;

    localparam logic [14:0] PEAK_CLIP = 15'd32767;

    // Report queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef struct packed {
        logic               func;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_item;

    typedef struct packed {
        logic [15:0] rms_left;
        logic [15:0] rms_right;
        logic [14:0] peak_left;
        logic [14:0] peak_right;
        logic [15:0] frames_seen;
    } t_result;

    // Window snapshot handed from front to back on a report
    typedef struct packed {
        logic signed [32:0] total_l;
        logic signed [32:0] total_r;
        logic [45:0]        energy_l;
        logic [45:0]        energy_r;
        logic [14:0]        peak_l;
        logic [14:0]        peak_r;
        logic [15:0]        frames;
    } t_snap;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_PL,
        S_PH,
        S_DIFF,
        S_SQRT,
        S_DIV,
        S_RES,
        S_DONE
    } t_back_state;

endpackage

`default_nettype wire

FILE: rtl/srpm_front.sv
// ----------------------------------------------------------------------------
// srpm_front
// Window accumulators: sums, square sums, frame count and peaks, one frame
// per cycle unless o_full. A report queues a snapshot and clears the window.
// ----------------------------------------------------------------------------
`default_nettype none

module srpm_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire srpm_pkg::t_item i_item,
    output logic                 o_snap_push,
    output srpm_pkg::t_snap      o_snap
);

    logic signed [32:0] r_total_l, n_total_l;
    logic signed [32:0] r_total_r, n_total_r;
    logic [45:0]        r_energy_l, n_energy_l;
    logic [45:0]        r_energy_r, n_energy_r;
    logic [15:0]        r_frames, n_frames;
    logic [14:0]        r_peak_l, n_peak_l;
    logic [14:0]        r_peak_r, n_peak_r;

    logic signed [31:0] sq_l, sq_r;
    logic [15:0]        mag16_l, mag16_r;
    logic [14:0]        mag_l, mag_r;
    logic               is_sample;

    assign sq_l = i_item.left_sample * i_item.left_sample;
    assign sq_r = i_item.right_sample * i_item.right_sample;

    // -32768 negates to itself; the top bit then selects the clip value
    assign mag16_l = i_item.left_sample[15] ? 16'(-i_item.left_sample) : i_item.left_sample;
    assign mag16_r = i_item.right_sample[15] ? 16'(-i_item.right_sample)
                                             : i_item.right_sample;
    assign mag_l = mag16_l[15] ? srpm_pkg::PEAK_CLIP : mag16_l[14:0];
    assign mag_r = mag16_r[15] ? srpm_pkg::PEAK_CLIP : mag16_r[14:0];

    assign is_sample   = (i_item.func == srpm_pkg::FUNC_SAMPLE);
    assign o_snap_push = i_accept && !is_sample;

    always_comb begin
        o_snap.total_l  = r_total_l;
        o_snap.total_r  = r_total_r;
        o_snap.energy_l = r_energy_l;
        o_snap.energy_r = r_energy_r;
        o_snap.peak_l   = r_peak_l;
        o_snap.peak_r   = r_peak_r;
        o_snap.frames   = r_frames;
    end

    always_comb begin
        n_total_l  = r_total_l;
        n_total_r  = r_total_r;
        n_energy_l = r_energy_l;
        n_energy_r = r_energy_r;
        n_frames   = r_frames;
        n_peak_l   = r_peak_l;
        n_peak_r   = r_peak_r;
        if (i_accept && is_sample) begin
            if (mag_l > r_peak_l) begin
                n_peak_l = mag_l;
            end
            if (mag_r > r_peak_r) begin
                n_peak_r = mag_r;
            end
            if (32'(r_frames) < 32'(srpm_pkg::FRAME_LIMIT)) begin
                n_total_l  = r_total_l + {{17{i_item.left_sample[15]}}, i_item.left_sample};
                n_total_r  = r_total_r + {{17{i_item.right_sample[15]}}, i_item.right_sample};
                n_energy_l = r_energy_l + {14'b0, sq_l};
                n_energy_r = r_energy_r + {14'b0, sq_r};
                n_frames   = r_frames + 16'd1;
            end
        end else if (i_accept) begin
            n_total_l  = '0;
            n_total_r  = '0;
            n_energy_l = '0;
            n_energy_r = '0;
            n_frames   = '0;
            n_peak_l   = '0;
            n_peak_r   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_l  <= '0;
            r_total_r  <= '0;
            r_energy_l <= '0;
            r_energy_r <= '0;
            r_frames   <= '0;
            r_peak_l   <= '0;
            r_peak_r   <= '0;
        end else begin
            r_total_l  <= n_total_l;
            r_total_r  <= n_total_r;
            r_energy_l <= n_energy_l;
            r_energy_r <= n_energy_r;
            r_frames   <= n_frames;
            r_peak_l   <= n_peak_l;
            r_peak_r   <= n_peak_r;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/srpm_queue.sv
// ----------------------------------------------------------------------------
// srpm_queue
// Short queue of window snapshots between the accumulators and the RMS unit.
// ----------------------------------------------------------------------------
`default_nettype none

module srpm_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire srpm_pkg::t_snap i_wdata,
    output logic                 o_full,
    input  wire logic            i_rd,
    output srpm_pkg::t_snap      o_rdata,
    output logic                 o_empty
);

    localparam int unsigned AW = srpm_pkg::QUEUE_AW;

    srpm_pkg::t_snap r_ent [srpm_pkg::QUEUE_DEPTH];

    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [AW:0]   r_count, n_count;
    logic          do_wr, do_rd;

    assign o_full  = (r_count == (AW+1)'(srpm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_ent[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == AW'(srpm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == AW'(srpm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_ent[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/srpm_back.sv
// ----------------------------------------------------------------------------
// srpm_back
// RMS sequencer: per channel D = n*sq - sum^2 via a shared 32x32 multiplier,
// s = isqrt(4D) one bit a cycle, q = s / n one bit a cycle, rms = (q+1)/2.
// ----------------------------------------------------------------------------
`default_nettype none

module srpm_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_snap_empty,
    input  wire srpm_pkg::t_snap   i_snap,
    output logic                   o_snap_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output srpm_pkg::t_result      o_result
);

    srpm_pkg::t_back_state r_state, n_state;

    srpm_pkg::t_snap   r_snap;
    srpm_pkg::t_result r_out;
    logic              r_out_valid;
    logic              r_ch;
    logic [63:0]       r_sq2;
    logic [63:0]       r_prod;
    logic [63:0]       r_x;
    logic [32:0]       r_rem;
    logic [31:0]       r_root;
    logic [15:0]       r_drem;
    logic [4:0]        r_cnt;
    logic [15:0]       r_rms_l, r_rms_r;

    logic               ld_out;
    logic               step_last;
    logic signed [32:0] tot;
    logic [32:0]        tot_abs;
    logic [45:0]        eng;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [63:0]        diff;
    logic [34:0]        sq_shift, sq_trial, sq_sub;
    logic               sq_ge;
    logic [16:0]        dv_shift, dv_sub;
    logic               dv_ge;
    logic [32:0]        q_round;

    assign tot     = r_ch ? r_snap.total_r : r_snap.total_l;
    assign eng     = r_ch ? r_snap.energy_r : r_snap.energy_l;
    assign tot_abs = tot[32] ? 33'(-tot) : tot;
    assign mul_p   = mul_a * mul_b;
    assign diff    = r_prod - r_sq2;

    // one root bit per step
    assign sq_shift = {r_rem, r_x[63:62]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);
    assign sq_sub   = sq_shift - sq_trial;

    // one quotient bit per step, dividend shifts out of r_root
    assign dv_shift = {r_drem, r_root[31]};
    assign dv_ge    = (dv_shift >= {1'b0, r_snap.frames});
    assign dv_sub   = dv_shift - {1'b0, r_snap.frames};

    assign q_round  = {1'b0, r_root} + 33'd1;
    assign step_last = (r_cnt == '0);

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srpm_pkg::S_IDLE: begin
                if (!i_snap_empty) begin
                    n_state = (i_snap.frames == '0) ? srpm_pkg::S_DONE : srpm_pkg::S_SQ;
                end
            end
            srpm_pkg::S_SQ:   n_state = srpm_pkg::S_PL;
            srpm_pkg::S_PL:   n_state = srpm_pkg::S_PH;
            srpm_pkg::S_PH:   n_state = srpm_pkg::S_DIFF;
            srpm_pkg::S_DIFF: n_state = srpm_pkg::S_SQRT;
            srpm_pkg::S_SQRT: begin
                if (step_last) begin
                    n_state = srpm_pkg::S_DIV;
                end
            end
            srpm_pkg::S_DIV: begin
                if (step_last) begin
                    n_state = srpm_pkg::S_RES;
                end
            end
            srpm_pkg::S_RES:  n_state = r_ch ? srpm_pkg::S_DONE : srpm_pkg::S_SQ;
            srpm_pkg::S_DONE: begin
                if (ld_out) begin
                    n_state = srpm_pkg::S_IDLE;
                end
            end
            default: n_state = srpm_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_snap_pop = 1'b0;
        ld_out     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            srpm_pkg::S_IDLE: o_snap_pop = !i_snap_empty;
            srpm_pkg::S_SQ: begin
                mul_a = tot_abs[31:0];
                mul_b = tot_abs[31:0];
            end
            srpm_pkg::S_PL: begin
                mul_a = {16'b0, r_snap.frames};
                mul_b = {9'b0, eng[22:0]};
            end
            srpm_pkg::S_PH: begin
                mul_a = {16'b0, r_snap.frames};
                mul_b = {9'b0, eng[45:23]};
            end
            srpm_pkg::S_DONE: ld_out = !r_out_valid || i_pop;
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            srpm_pkg::S_IDLE: begin
                r_snap  <= i_snap;
                r_rms_l <= '0;
                r_rms_r <= '0;
            end
            srpm_pkg::S_SQ:   r_sq2  <= mul_p;
            srpm_pkg::S_PL:   r_prod <= mul_p;
            srpm_pkg::S_PH:   r_prod <= r_prod + {mul_p[40:0], 23'b0};
            srpm_pkg::S_DIFF: begin
                r_x    <= (r_prod > r_sq2) ? {diff[61:0], 2'b00} : '0;
                r_rem  <= '0;
                r_root <= '0;
                r_drem <= '0;
                r_cnt  <= 5'd31;
            end
            srpm_pkg::S_SQRT: begin
                r_rem  <= sq_ge ? sq_sub[32:0] : sq_shift[32:0];
                r_root <= {r_root[30:0], sq_ge};
                r_x    <= {r_x[61:0], 2'b00};
                r_cnt  <= r_cnt - 5'd1;
            end
            srpm_pkg::S_DIV: begin
                r_drem <= dv_ge ? dv_sub[15:0] : dv_shift[15:0];
                r_root <= {r_root[30:0], dv_ge};
                r_cnt  <= r_cnt - 5'd1;
            end
            srpm_pkg::S_RES: begin
                if (r_ch) begin
                    r_rms_r <= q_round[16:1];
                end else begin
                    r_rms_l <= q_round[16:1];
                end
            end
            srpm_pkg::S_DONE: begin
                if (ld_out) begin
                    r_out.rms_left    <= r_rms_l;
                    r_out.rms_right   <= r_rms_r;
                    r_out.peak_left   <= r_snap.peak_l;
                    r_out.peak_right  <= r_snap.peak_r;
                    r_out.frames_seen <= r_snap.frames;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srpm_pkg::S_IDLE;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == srpm_pkg::S_IDLE) begin
                r_ch <= 1'b0;
            end else if (r_state == srpm_pkg::S_RES) begin
                r_ch <= 1'b1;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/stereo_rms_peak_meter.sv
// ----------------------------------------------------------------------------
// stereo_rms_peak_meter
// Stereo level meter: per-window DC-removed RMS, peaks and frame count.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  item      in         i_push / o_full     i_item   (srpm_pkg::t_item)
//  result    out        o_empty / i_pop     o_result (srpm_pkg::t_result)
//
//  Sample items are taken one per cycle while o_full is low; the accumulators
//  update in that cycle. A report snapshots the window into a two-entry queue;
//  per channel the RMS sequencer runs the multiply/setup states, 32 root steps,
//  32 divide steps and a rounding state. o_full rises while the queue holds two
//  unfinished reports. Synchronous reset clears the window, queue and result.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_rms_peak_meter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire srpm_pkg::t_item   i_item,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output srpm_pkg::t_result      o_result
);

    logic            accept;
    logic            snap_push;
    logic            snap_pop;
    logic            snap_empty;
    srpm_pkg::t_snap snap_in;
    srpm_pkg::t_snap snap_out;

    assign accept = i_push && !o_full;

    srpm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_snap_push (snap_push),
        .o_snap      (snap_in)
    );

    srpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (snap_push),
        .i_wdata (snap_in),
        .o_full  (o_full),
        .i_rd    (snap_pop),
        .o_rdata (snap_out),
        .o_empty (snap_empty)
    );

    srpm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_empty (snap_empty),
        .i_snap       (snap_out),
        .o_snap_pop   (snap_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

FILE: test/stereo_rms_peak_meter_tb.sv
// ----------------------------------------------------------------------------
// stereo_rms_peak_meter_tb
// Self-checking bench for the stereo RMS / peak meter.
// Drives sample and report items through the push/full port and checks each
// popped report, field by field, against a cycle-free meter model kept here.
// A short directed table covers empty windows, full-scale swings, DC-only
// input and the clipped -32768 peak. Random windows of mixed shape follow.
// ----------------------------------------------------------------------------
module stereo_rms_peak_meter_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        srpm_pkg::t_item   it;
        bit                known;
        srpm_pkg::t_result res;
    } t_plan_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_push  = 1'b0;
    logic              i_pop   = 1'b0;
    srpm_pkg::t_item   i_item  = '0;
    logic              o_full;
    logic              o_empty;
    srpm_pkg::t_result o_result;

    // meter model state
    logic signed [32:0] win_sum_l, win_sum_r;
    logic [45:0]        win_energy_l, win_energy_r;
    logic [15:0]        win_frames;
    logic [14:0]        win_peak_l, win_peak_r;

    srpm_pkg::t_result expected_reports[$];
    t_plan_row         plan_rows[$];
    srpm_pkg::t_result want;
    int                fail_count  = 0;
    int                cycle_count = 0;
    bit                idle_on     = 1'b1;

    stereo_rms_peak_meter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_item   (i_item),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic srpm_pkg::t_item mk_item(logic f, int l, int r);
        srpm_pkg::t_item it;
        it.func         = f;
        it.left_sample  = 16'(l);
        it.right_sample = 16'(r);
        return it;
    endfunction

    function automatic srpm_pkg::t_result mk_result(int rl, int rr, int pl, int pr,
                                                    int n);
        srpm_pkg::t_result res;
        res.rms_left    = 16'(rl);
        res.rms_right   = 16'(rr);
        res.peak_left   = 15'(pl);
        res.peak_right  = 15'(pr);
        res.frames_seen = 16'(n);
        return res;
    endfunction

    function automatic void plan_add(srpm_pkg::t_item it, bit known,
                                     srpm_pkg::t_result res);
        t_plan_row row;
        row.it    = it;
        row.known = known;
        row.res   = res;
        plan_rows.push_back(row);
    endfunction

    // Largest r with (2r-1)^2 * n^2 <= 4 * (n*energy - sum^2); binary search.
    function automatic logic [15:0] dc_free_rms(logic signed [32:0] sum,
                                                logic [45:0] energy,
                                                logic [15:0] n);
        longint      s;
        logic [63:0] mag, sq2, prod, d4, a;
        logic [16:0] lo, hi, mid;
        if (n == 0)
            return 16'd0;
        s    = sum;
        mag  = (s < 0) ? 64'(-s) : 64'(s);
        sq2  = mag * mag;
        prod = 64'(n) * 64'(energy);
        if (prod <= sq2)
            return 16'd0;
        d4 = (prod - sq2) << 2;
        lo = 17'd0;
        hi = 17'd32768;
        while (lo < hi) begin
            mid = lo + (hi - lo + 17'd1) / 17'd2;
            a   = (64'(mid) * 64'd2 - 64'd1) * 64'(n);
            if (a * a <= d4)
                lo = mid;
            else
                hi = mid - 17'd1;
        end
        return lo[15:0];
    endfunction

    function automatic void meter_clear();
        win_sum_l    = '0;
        win_sum_r    = '0;
        win_energy_l = '0;
        win_energy_r = '0;
        win_frames   = '0;
        win_peak_l   = '0;
        win_peak_r   = '0;
    endfunction

    function automatic void meter_step(input srpm_pkg::t_item it,
                                       output bit has_report,
                                       output srpm_pkg::t_result rep);
        int l, r, mag_l, mag_r;
        has_report = 1'b0;
        rep        = '0;
        if (it.func == srpm_pkg::FUNC_SAMPLE) begin
            l     = $signed(it.left_sample);
            r     = $signed(it.right_sample);
            mag_l = (l < 0) ? -l : l;
            mag_r = (r < 0) ? -r : r;
            if (mag_l > 32767) mag_l = 32767;
            if (mag_r > 32767) mag_r = 32767;
            if (mag_l > int'(win_peak_l)) win_peak_l = 15'(mag_l);
            if (mag_r > int'(win_peak_r)) win_peak_r = 15'(mag_r);
            // past the frame limit only the peaks move
            if (win_frames < srpm_pkg::FRAME_LIMIT) begin
                win_sum_l    = win_sum_l + 33'(l);
                win_sum_r    = win_sum_r + 33'(r);
                win_energy_l = win_energy_l + 46'(longint'(l) * longint'(l));
                win_energy_r = win_energy_r + 46'(longint'(r) * longint'(r));
                win_frames   = win_frames + 16'd1;
            end
        end else begin
            has_report      = 1'b1;
            rep.rms_left    = dc_free_rms(win_sum_l, win_energy_l, win_frames);
            rep.rms_right   = dc_free_rms(win_sum_r, win_energy_r, win_frames);
            rep.peak_left   = win_peak_l;
            rep.peak_right  = win_peak_r;
            rep.frames_seen = win_frames;
            meter_clear();
        end
    endfunction

    function automatic logic signed [15:0] draw_sample(int style, int dc);
        int v;
        case (style)
            0: v = $signed(16'($urandom));
            1: v = dc + int'($urandom_range(0, 200)) - 100;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            3: v = int'($urandom_range(0, 64)) - 32;
            default: v = int'($urandom_range(0, 40000)) - 20000;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic void check_field(string name, int unsigned exp_v,
                                        int unsigned act_v);
        if (exp_v != act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endfunction

    // Present one item from the falling edge, hold it until accepted.
    task automatic send_item(input srpm_pkg::t_item it, input bit known,
                             input srpm_pkg::t_result lit);
        bit                got;
        srpm_pkg::t_result pred;
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 15) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
        meter_step(it, got, pred);
        if (got)
            expected_reports.push_back(known ? lit : pred);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_pop <= !(idle_on && $urandom_range(0, 99) < 15);

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_reports.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected report, expected none, actual %p",
                         $time, o_result);
            end else begin
                want = expected_reports.pop_front();
                check_field("rms_left",    want.rms_left,    o_result.rms_left);
                check_field("rms_right",   want.rms_right,   o_result.rms_right);
                check_field("peak_left",   want.peak_left,   o_result.peak_left);
                check_field("peak_right",  want.peak_right,  o_result.peak_right);
                check_field("frames_seen", want.frames_seen, o_result.frames_seen);
            end
        end
    end

    initial begin
        int sent, len, style, dc;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        meter_clear();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        plan_add(mk_item(srpm_pkg::FUNC_REPORT, 0, 0), 1'b1, mk_result(0, 0, 0, 0, 0));
        plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, -32768, 32767), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, 32767, -32768), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_REPORT, -1, -1), 1'b1,
                 mk_result(32768, 32768, 32767, 32767, 2));
        plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, 0, 0), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_REPORT, 0, 0), 1'b1, mk_result(0, 0, 0, 0, 1));
        plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, -1, 1), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, 1, -1), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_REPORT, 0, 0), 1'b1, mk_result(1, 1, 1, 1, 2));
        // DC-only window: variance zero
        repeat (3) plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, 7, -7), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_REPORT, 0, 0), 1'b1, mk_result(0, 0, 7, 7, 3));
        plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, 100, -200), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, -300, 5), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, 12345, -4321), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_SAMPLE, -32767, 16384), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_REPORT, 0, 0), 1'b0, '0);
        plan_add(mk_item(srpm_pkg::FUNC_REPORT, 0, 0), 1'b1, mk_result(0, 0, 0, 0, 0));
        foreach (plan_rows[k])
            send_item(plan_rows[k].it, plan_rows[k].known, plan_rows[k].res);

        // random windows
        while (sent < RANDOM_ITEMS) begin
            idle_on = !(sent >= 500 && sent < 850);
            if (!paused && sent >= 500) begin
                @(negedge i_clk);
                i_push <= 1'b0;
                while (expected_reports.size() != 0)
                    @(posedge i_clk);
                paused = 1'b1;
            end
            len   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 24)
                                               : $urandom_range(25, 120);
            style = $urandom_range(0, 4);
            dc    = int'($urandom_range(0, 60000)) - 30000;
            repeat (len) begin
                send_item(mk_item(srpm_pkg::FUNC_SAMPLE, draw_sample(style, dc),
                                  draw_sample(style, dc)), 1'b0, '0);
                sent++;
            end
            send_item(mk_item(srpm_pkg::FUNC_REPORT, $urandom, $urandom), 1'b0, '0);
            sent++;
        end
        idle_on = 1'b1;

        @(negedge i_clk);
        i_push <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: stereo_rms_peak_meter.f
rtl/srpm_pkg.sv
rtl/srpm_front.sv
rtl/srpm_queue.sv
rtl/srpm_back.sv
rtl/stereo_rms_peak_meter.sv
test/stereo_rms_peak_meter_tb.sv
